// ----- hdl/tspg_pkg.sv -----
`default_nettype none

package tspg_pkg;

   // Width of the half period and tick counters
   localparam int unsigned PERIOD_WIDTH = 16;

   localparam int unsigned WEIGHT_WIDTH = 24;
   localparam int unsigned CFG_WIDTH    = 16;
   localparam int unsigned COUNT_WIDTH  = 16;
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = WEIGHT_WIDTH;

   // Item kinds
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   // Register indexes
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_SWITCH_LEVEL       = 3'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_DIRECTION_DEADBAND = 3'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_START_HALF_PERIOD  = 3'd2;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_FLOOR_HALF_PERIOD  = 3'd3;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_RAMP_STEP          = 3'd4;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_ACCEL_STEPS        = 3'd5;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_CRUISE_STEPS       = 3'd6;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_DECEL_STEPS        = 3'd7;

   // Register reset values
   localparam logic [WEIGHT_WIDTH-1:0] RST_SWITCH_LEVEL       = 24'd10000;
   localparam logic [CFG_WIDTH-1:0]    RST_DIRECTION_DEADBAND = 16'd100;
   localparam logic [CFG_WIDTH-1:0]    RST_START_HALF_PERIOD  = 16'd1000;
   localparam logic [CFG_WIDTH-1:0]    RST_FLOOR_HALF_PERIOD  = 16'd100;
   localparam logic [CFG_WIDTH-1:0]    RST_RAMP_STEP          = 16'd2;
   localparam logic [CFG_WIDTH-1:0]    RST_ACCEL_STEPS        = 16'd500;
   localparam logic [CFG_WIDTH-1:0]    RST_CRUISE_STEPS       = 16'd1000;
   localparam logic [CFG_WIDTH-1:0]    RST_DECEL_STEPS        = 16'd500;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_ACCEL  = 2'd1,
      PH_CRUISE = 2'd2,
      PH_DECEL  = 2'd3
   } phase_type;

   typedef struct packed {
      logic [WEIGHT_WIDTH-1:0] switch_level;
      logic [CFG_WIDTH-1:0]    direction_deadband;
      logic [CFG_WIDTH-1:0]    start_half_period;
      logic [CFG_WIDTH-1:0]    floor_half_period;
      logic [CFG_WIDTH-1:0]    ramp_step;
      logic [CFG_WIDTH-1:0]    accel_steps;
      logic [CFG_WIDTH-1:0]    cruise_steps;
      logic [CFG_WIDTH-1:0]    decel_steps;
   } cfg_type;

   typedef struct packed {
      logic pulse_level;
      logic direction;
      logic busy_res;
      logic move_done;
   } result_type;

   // First phase after from_phase that has a nonzero step count; idle when none is left
   function automatic phase_type next_active(phase_type from_phase, cfg_type cfg);
      logic      acc_on;
      logic      cru_on;
      logic      dec_on;
      phase_type nxt;
      acc_on = (cfg.accel_steps != '0);
      cru_on = (cfg.cruise_steps != '0);
      dec_on = (cfg.decel_steps != '0);
      nxt    = PH_IDLE;
      case (from_phase)
         PH_IDLE: begin
            if (acc_on)      nxt = PH_ACCEL;
            else if (cru_on) nxt = PH_CRUISE;
            else if (dec_on) nxt = PH_DECEL;
         end
         PH_ACCEL: begin
            if (cru_on)      nxt = PH_CRUISE;
            else if (dec_on) nxt = PH_DECEL;
         end
         PH_CRUISE: begin
            if (dec_on)      nxt = PH_DECEL;
         end
         default: nxt = PH_IDLE;
      endcase
      return nxt;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/trapezoid_step_pulse_generator.sv -----
// Trapezoidal step pulse generator.
// Input stream (req_): one item per microsecond tick (tuser = 0) or a start item
// (tuser = 1) with a 24-bit weight in tdata that, if idle, sets the direction beyond the
// deadband and begins a move: acceleration, cruise, deceleration, each a set number of steps.
// Result stream (rsp_): exactly one item per input item, with the pulse level,
// direction and busy flag in tdata and tlast marking the item that ends a move.
// Configuration: csr_we writes csr_wdata into register csr_addr at the clock edge;
// write only while no item is in flight.
// An accepted item waits in the input register and its result then loads into
// the result register, which drives rsp_tvalid; a stalled receiver can hold
// the item in the input register until the result register empties.
// Throughput: one item per cycle while rsp_tready is high; the whole profile update for one
// item is one counter increment, compare and half-period add or subtract, all combinational.
// A stalled receiver holds the result register; the input register keeps taking
// items until it is full too, then req_tready drops.
// Reset clears the valid flags of both registers, the profile state and the direction, and
// loads the configuration registers with their default values.

`default_nettype none

module trapezoid_step_pulse_generator (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [tspg_pkg::WEIGHT_WIDTH-1:0]      req_tdata,  // [23:0] weight
   input  wire logic [0:0]                             req_tuser,  // [0] op
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [7:0]                                  rsp_tdata,  // [0] pulse_level,
                                                                   // [1] direction,
                                                                   // [2] busy_res, [7:3] zero
   output logic                                        rsp_tlast,  // move_done
   input  wire logic                                   csr_we,
   input  wire logic [tspg_pkg::CSR_ADDR_WIDTH-1:0]    csr_addr,
   input  wire logic [tspg_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int unsigned CW = tspg_pkg::CFG_WIDTH;

   tspg_pkg::cfg_type    cfg_ff, cfg_in;

   logic                            in_valid_ff, in_valid_in;
   logic                            in_op_ff, in_op_in;
   logic [tspg_pkg::WEIGHT_WIDTH-1:0] in_weight_ff, in_weight_in;

   logic                            out_valid_ff, out_valid_in;
   tspg_pkg::result_type            out_res_ff, out_res_in;
   tspg_pkg::result_type            core_res;

   logic                            advance;
   logic                            req_fire;

   // Move the held item into the result register when that register is free or emptying
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            tspg_pkg::CSR_SWITCH_LEVEL:       cfg_in.switch_level       = csr_wdata;
            tspg_pkg::CSR_DIRECTION_DEADBAND: cfg_in.direction_deadband = csr_wdata[CW-1:0];
            tspg_pkg::CSR_START_HALF_PERIOD:  cfg_in.start_half_period  = csr_wdata[CW-1:0];
            tspg_pkg::CSR_FLOOR_HALF_PERIOD:  cfg_in.floor_half_period  = csr_wdata[CW-1:0];
            tspg_pkg::CSR_RAMP_STEP:          cfg_in.ramp_step          = csr_wdata[CW-1:0];
            tspg_pkg::CSR_ACCEL_STEPS:        cfg_in.accel_steps        = csr_wdata[CW-1:0];
            tspg_pkg::CSR_CRUISE_STEPS:       cfg_in.cruise_steps       = csr_wdata[CW-1:0];
            tspg_pkg::CSR_DECEL_STEPS:        cfg_in.decel_steps        = csr_wdata[CW-1:0];
            default:                          cfg_in = cfg_ff;
         endcase
      end
   end

   // Input register: load on acceptance, drop once passed on
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_op_in     = in_op_ff;
      in_weight_in = in_weight_ff;
      if (advance) in_valid_in = 1'b0;
      if (req_fire) begin
         in_valid_in  = 1'b1;
         in_op_in     = req_tuser[0];
         in_weight_in = req_tdata;
      end
   end

   tspg_core u_core (
      .clock       (clock),
      .reset       (reset),
      .item_en     (advance),
      .item_op     (in_op_ff),
      .item_weight (in_weight_ff),
      .cfg         (cfg_ff),
      .result      (core_res)
   );

   // Result register: hold while stalled
   always_comb begin
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (rsp_tready) out_valid_in = 1'b0;
      if (advance) begin
         out_valid_in = 1'b1;
         out_res_in   = core_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.switch_level       <= tspg_pkg::RST_SWITCH_LEVEL;
         cfg_ff.direction_deadband <= tspg_pkg::RST_DIRECTION_DEADBAND;
         cfg_ff.start_half_period  <= tspg_pkg::RST_START_HALF_PERIOD;
         cfg_ff.floor_half_period  <= tspg_pkg::RST_FLOOR_HALF_PERIOD;
         cfg_ff.ramp_step          <= tspg_pkg::RST_RAMP_STEP;
         cfg_ff.accel_steps        <= tspg_pkg::RST_ACCEL_STEPS;
         cfg_ff.cruise_steps       <= tspg_pkg::RST_CRUISE_STEPS;
         cfg_ff.decel_steps        <= tspg_pkg::RST_DECEL_STEPS;
         in_valid_ff               <= 1'b0;
         out_valid_ff              <= 1'b0;
      end else begin
         cfg_ff                    <= cfg_in;
         in_valid_ff               <= in_valid_in;
         out_valid_ff              <= out_valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      in_op_ff     <= in_op_in;
      in_weight_ff <= in_weight_in;
      out_res_ff   <= out_res_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_res_ff.busy_res, out_res_ff.direction, out_res_ff.pulse_level};
   assign rsp_tlast  = out_res_ff.move_done;

endmodule

`default_nettype wire

// ----- hdl/tspg_core.sv -----
`default_nettype none

module tspg_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  item_en,
   input  wire logic                                  item_op,
   input  wire logic [tspg_pkg::WEIGHT_WIDTH-1:0]     item_weight,
   input  wire tspg_pkg::cfg_type                     cfg,
   output tspg_pkg::result_type                       result
);

   localparam int unsigned PW = tspg_pkg::PERIOD_WIDTH;
   localparam int unsigned CW = tspg_pkg::COUNT_WIDTH;
   localparam int unsigned WW = tspg_pkg::WEIGHT_WIDTH;

   tspg_pkg::phase_type phase_ff, phase_in;
   logic [CW-1:0]       steps_done_ff, steps_done_in;
   logic [PW-1:0]       half_period_ff, half_period_in;
   logic [PW-1:0]       tick_count_ff, tick_count_in;
   logic                pulse_high_ff, pulse_high_in;
   logic                dir_level_ff, dir_level_in;

   logic                is_start;
   logic                is_idle;
   tspg_pkg::phase_type start_phase;
   tspg_pkg::phase_type follow_phase;
   logic [PW-1:0]       floor_pw;
   logic [PW-1:0]       ramp_pw;
   logic [PW-1:0]       hp_raw;
   logic [PW-1:0]       hp_eff;
   logic [PW-1:0]       tick_inc;
   logic                half_done;
   logic [CW-1:0]       steps_inc;
   logic [CW-1:0]       phase_cnt;
   logic                phase_end;
   logic [PW-1:0]       ramp_hp;
   logic [WW:0]         dir_sum;
   logic [WW:0]         dir_diff;
   logic                dir_up;
   logic                dir_down;

   assign is_start     = (item_op == tspg_pkg::OP_START);
   assign is_idle      = (phase_ff == tspg_pkg::PH_IDLE);
   assign start_phase  = tspg_pkg::next_active(tspg_pkg::PH_IDLE, cfg);
   assign follow_phase = tspg_pkg::next_active(phase_ff, cfg);
   assign floor_pw     = PW'(cfg.floor_half_period);
   assign ramp_pw      = PW'(cfg.ramp_step);

   assign hp_raw    = (phase_ff == tspg_pkg::PH_CRUISE) ? floor_pw : half_period_ff;
   assign hp_eff    = (hp_raw == '0) ? PW'(1) : hp_raw;
   assign tick_inc  = tick_count_ff + PW'(1);
   assign half_done = (tick_inc >= hp_eff) || (tick_inc == '0);
   assign steps_inc = steps_done_ff + CW'(1);
   assign phase_end = (steps_inc >= phase_cnt) || (steps_inc == '0);

   // Direction: the low compare only counts when weight minus deadband does not borrow
   assign dir_sum  = {1'b0, item_weight} + (WW+1)'(cfg.direction_deadband);
   assign dir_diff = {1'b0, item_weight} - (WW+1)'(cfg.direction_deadband);
   assign dir_up   = dir_sum > {1'b0, cfg.switch_level};
   assign dir_down = !dir_diff[WW] && (dir_diff[WW-1:0] < cfg.switch_level);

   always_comb begin
      unique case (phase_ff)
         tspg_pkg::PH_ACCEL:  phase_cnt = cfg.accel_steps;
         tspg_pkg::PH_CRUISE: phase_cnt = cfg.cruise_steps;
         default:             phase_cnt = cfg.decel_steps;
      endcase
   end

   always_comb begin
      unique case (phase_ff)
         tspg_pkg::PH_ACCEL:
            ramp_hp = (half_period_ff > floor_pw) ? half_period_ff - ramp_pw : half_period_ff;
         tspg_pkg::PH_DECEL:
            ramp_hp = half_period_ff + ramp_pw;
         default:
            ramp_hp = half_period_ff;
      endcase
   end

   // Next state
   always_comb begin
      phase_in       = phase_ff;
      steps_done_in  = steps_done_ff;
      half_period_in = half_period_ff;
      tick_count_in  = tick_count_ff;
      pulse_high_in  = pulse_high_ff;
      dir_level_in   = dir_level_ff;
      if (item_en) begin
         if (is_start) begin
            if (is_idle) begin
               if (dir_up)        dir_level_in = 1'b1;
               else if (dir_down) dir_level_in = 1'b0;
               half_period_in = PW'(cfg.start_half_period);
               phase_in       = start_phase;
               steps_done_in  = '0;
               tick_count_in  = '0;
               pulse_high_in  = (start_phase != tspg_pkg::PH_IDLE);
            end
         end else if (!is_idle) begin
            tick_count_in = tick_inc;
            if (half_done) begin
               tick_count_in = '0;
               if (pulse_high_ff) begin
                  pulse_high_in = 1'b0;
               end else begin
                  half_period_in = ramp_hp;
                  steps_done_in  = steps_inc;
                  if (phase_end) begin
                     phase_in      = follow_phase;
                     steps_done_in = '0;
                     pulse_high_in = (follow_phase != tspg_pkg::PH_IDLE);
                  end else begin
                     pulse_high_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   // Result of the current item
   always_comb begin
      result           = '0;
      result.direction = dir_level_in;
      if (is_start) begin
         if (is_idle) begin
            result.pulse_level = (start_phase != tspg_pkg::PH_IDLE);
            result.busy_res    = (start_phase != tspg_pkg::PH_IDLE);
            result.move_done   = (start_phase == tspg_pkg::PH_IDLE);
         end else begin
            result.pulse_level = pulse_high_ff;
            result.busy_res    = 1'b1;
         end
      end else if (!is_idle) begin
         result.pulse_level = pulse_high_ff;
         result.busy_res    = 1'b1;
         result.move_done   = half_done && !pulse_high_ff && phase_end
                              && (follow_phase == tspg_pkg::PH_IDLE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= tspg_pkg::PH_IDLE;
         steps_done_ff  <= '0;
         half_period_ff <= '0;
         tick_count_ff  <= '0;
         pulse_high_ff  <= 1'b0;
         dir_level_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         steps_done_ff  <= steps_done_in;
         half_period_ff <= half_period_in;
         tick_count_ff  <= tick_count_in;
         pulse_high_ff  <= pulse_high_in;
         dir_level_ff   <= dir_level_in;
      end
   end

endmodule

`default_nettype wire
